### src/torus_mesh_vertex_generator_macros.svh
// assertion macros for the torus mesh vertex generator
// included by the top level; no other dependencies
`ifndef TORUS_MESH_VERTEX_GENERATOR_MACROS_SVH
`define TORUS_MESH_VERTEX_GENERATOR_MACROS_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define TMVG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// antecedent implies consequent in the next cycle
`define TMVG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TMVG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define TMVG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### src/tmvg_pkg.sv
// shared types, constants and helpers of the torus mesh vertex generator
// no dependencies
package tmvg_pkg;

   localparam int IDX_W     = 8;
   localparam int ROWS      = 2 ** IDX_W;
   localparam int TAG_W     = IDX_W + 1;
   localparam int DIV_W     = 9;
   localparam int RAD_W     = 8;
   localparam int ANGLE_W   = 16;
   localparam int TRIG_W    = 16;
   localparam int RHO_W     = 25;
   localparam int POS_W     = 18;
   localparam int SLOT_W    = 3;
   localparam int PROD_W    = RHO_W + TRIG_W;
   localparam int WIDE_W    = 48;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);

   localparam int ONE_Q14   = 16384;
   localparam int Q14_HALF  = 8192;
   localparam int POLY_A    = 25736;
   localparam int POLY_B    = 10512;
   localparam int POLY_C    = 1160;

   localparam int MAX_DIVISIONS     = 256;
   localparam int DEF_FRACTION_BITS = 8;
   localparam int RST_DIVISIONS     = 20;
   localparam int RST_MAJOR         = 10;
   localparam int RST_MINOR         = 2;

   localparam logic [SLOT_W-1:0] LAST_SLOT = 3'd5;

   typedef enum logic [1:0] {
      CSR_RING_DIV = 2'd0,
      CSR_TUBE_DIV = 2'd1,
      CSR_MAJOR    = 2'd2,
      CSR_MINOR    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [RHO_W-1:0] rho;
      logic signed [POS_W-1:0] z;
   } ring_entry_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cosv;
      logic signed [TRIG_W-1:0] sinv;
   } tube_entry_type;

   // hi holds index k+1, lo holds index k
   typedef struct packed {
      ring_entry_type hi;
      ring_entry_type lo;
   } ring_row_type;

   typedef struct packed {
      tube_entry_type hi;
      tube_entry_type lo;
   } tube_row_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      ring_row_type     ring;
      tube_row_type     tube;
   } table_wr_type;

   typedef struct packed {
      logic [IDX_W-1:0] ring_idx;
      logic [IDX_W-1:0] tube_idx;
      logic             bad;
   } cell_type;

   typedef struct packed {
      logic     valid;
      cell_type item;
   } queue_out_type;

   // slot uses the next ring angle
   function automatic logic next_ring(input logic [SLOT_W-1:0] slot);
      case (slot) inside
         3'd1, 3'd2, 3'd4: return 1'b1;
         default:          return 1'b0;
      endcase
   endfunction

   // slot uses the next tube angle
   function automatic logic next_tube(input logic [SLOT_W-1:0] slot);
      case (slot) inside
         3'd1, 3'd3, 3'd4: return 1'b1;
         default:          return 1'b0;
      endcase
   endfunction

   // saturate to the signed coordinate range
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'((2 ** (POS_W - 1)) - 1);
      lo = -hi - WIDE_W'(1);
      if (v > hi) begin
         return POS_W'(hi);
      end else if (v < lo) begin
         return POS_W'(lo);
      end
      return POS_W'(v);
   endfunction

endpackage

### src/torus_mesh_vertex_generator.sv
// channel  dir  fields (low bit first)
// req      in   tdata: ring_index[7:0], tube_index[15:8]
// rsp      out  tdata: pos_x, pos_y, pos_z, vertex_slot; tlast: last_vertex;
//               tuser: bad_index
// csr      in   wen, index, wdata (9 bits)
//
// a valid cell gives six vertices, one per cycle unless the result side stalls, from
// the back pipeline's table read and its pair of rho multipliers; a bad cell gives one
// an accepted item is queued, then passes the table read, multiplier and output registers
// after reset and after every register write the angle tables are rebuilt
// (17 divide steps, 257 angles, pipeline drain); req_tready stays low
// a 4-deep queue lets input items keep arriving while the result side stalls
//
// top level; depends on tmvg_pkg, tmvg_front, tmvg_builder, tmvg_back and the macro header
`include "torus_mesh_vertex_generator_macros.svh"
module torus_mesh_vertex_generator
   import tmvg_pkg::*;
#(
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,   // ring_index, tube_index
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [63:0]      rsp_tdata,   // pos_x, pos_y, pos_z, vertex_slot
   output logic             rsp_tlast,
   output logic             rsp_tuser,   // bad_index
   input  logic             csr_wen,
   input  logic [1:0]       csr_index,
   input  logic [DIV_W-1:0] csr_wdata
);

   localparam logic [DIV_W-1:0] DIV_RST = (RST_DIVISIONS > MAX_DIVISIONS) ?
                                          DIV_W'(MAX_DIVISIONS) : DIV_W'(RST_DIVISIONS);

   logic [DIV_W-1:0] ring_div_ff, tube_div_ff, div_in;
   logic [RAD_W-1:0] major_ff, minor_ff;
   table_wr_type     table_wr;
   queue_out_type    head;
   logic             table_ready, pop;

   // division count clamp
   assign div_in = (int'(csr_wdata) > MAX_DIVISIONS) ? DIV_W'(MAX_DIVISIONS) : csr_wdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_div_ff <= DIV_RST;
         tube_div_ff <= DIV_RST;
         major_ff    <= RAD_W'(RST_MAJOR);
         minor_ff    <= RAD_W'(RST_MINOR);
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_RING_DIV: ring_div_ff <= div_in;
            CSR_TUBE_DIV: tube_div_ff <= div_in;
            CSR_MAJOR:    major_ff    <= csr_wdata[RAD_W-1:0];
            CSR_MINOR:    minor_ff    <= csr_wdata[RAD_W-1:0];
            default:      ;
         endcase
      end
   end

   tmvg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .ring_div    (ring_div_ff),
      .tube_div    (tube_div_ff),
      .table_ready (table_ready),
      .pop         (pop),
      .head        (head)
   );

   tmvg_builder #(.FRACTION_BITS(FRACTION_BITS)) u_builder (
      .clock        (clock),
      .reset        (reset),
      .start        (csr_wen),
      .ring_div     (ring_div_ff),
      .tube_div     (tube_div_ff),
      .major_radius (major_ff),
      .minor_radius (minor_ff),
      .table_wr     (table_wr),
      .done         (table_ready)
   );

   tmvg_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .table_wr   (table_wr),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // checks
   `TMVG_ASSERT_IMPLY(a_bad_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast && (rsp_tdata[56:0] == 57'd0), "bad cell item not zeroed")
   `TMVG_ASSERT_IMPLY(a_last_slot, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast == (rsp_tdata[56:54] == LAST_SLOT), "last flag off slot five")
   `TMVG_ASSERT_NEXT(a_rebuild, clock, reset, csr_wen, !req_tready, "input taken during table rebuild")
   `TMVG_ASSERT_IMPLY(a_no_write_busy, clock, reset, table_wr.en, !table_ready, "table written while ready")

endmodule

### src/tmvg_sincos.sv
// pipelined sine and cosine of a 16-bit turn angle, Q1.14 results
// depends on tmvg_pkg
module tmvg_sincos
   import tmvg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [ANGLE_W-1:0]       in_angle,
   input  logic [TAG_W-1:0]         in_tag,
   output logic                     out_valid,
   output logic [TAG_W-1:0]         out_tag,
   output logic signed [TRIG_W-1:0] out_sin,
   output logic signed [TRIG_W-1:0] out_cos,
   output logic                     busy
);

   localparam int STAGES = 5;

   logic [STAGES-1:0] valid_ff;
   logic [TAG_W-1:0]  tag_ff [STAGES];

   // lane 0 is sine, lane 1 is cosine
   logic [14:0]              x0_ff [2];
   logic [14:0]              x1_ff [2];
   logic [14:0]              x2_ff [2];
   logic [14:0]              x3_ff [2];
   logic [14:0]              x4_ff [2];
   logic [3:0]               neg_ff [2];
   logic [14:0]              sq_ff [2];
   logic [10:0]              t_ff  [2];
   logic [13:0]              v_ff  [2];
   logic signed [TRIG_W-1:0] s_ff  [2];

   logic [ANGLE_W-1:0] lane_angle [2];
   logic [29:0]        m1 [2];
   logic [25:0]        m2 [2];
   logic [28:0]        m3 [2];
   logic [29:0]        m4 [2];
   logic [15:0]        mag [2];

   // per-lane products
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         lane_angle[l] = in_angle + (l == 1 ? ANGLE_W'(ONE_Q14) : '0);
         m1[l]  = 30'(x0_ff[l]) * 30'(x0_ff[l]);
         m2[l]  = 26'(POLY_C) * 26'(sq_ff[l]);
         m3[l]  = 29'(14'(POLY_B) - 14'(t_ff[l])) * 29'(x2_ff[l]);
         m4[l]  = 30'(x4_ff[l]) * 30'(15'(POLY_A) - 15'(v_ff[l]));
         mag[l] = 16'((m4[l] + 30'(Q14_HALF)) >> 14);
         if (mag[l] > 16'(ONE_Q14)) begin
            mag[l] = 16'(ONE_Q14);
         end
      end
   end

   // polynomial stages
   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         x0_ff[l]  <= lane_angle[l][14] ? 15'(ONE_Q14) - {1'b0, lane_angle[l][13:0]}
                                        : {1'b0, lane_angle[l][13:0]};
         neg_ff[l] <= {neg_ff[l][2:0], lane_angle[l][15]};
         sq_ff[l]  <= 15'((m1[l] + 30'(Q14_HALF)) >> 14);
         x1_ff[l]  <= x0_ff[l];
         t_ff[l]   <= 11'((m2[l] + 26'(Q14_HALF)) >> 14);
         x2_ff[l]  <= sq_ff[l];
         x3_ff[l]  <= x1_ff[l];
         v_ff[l]   <= 14'((m3[l] + 29'(Q14_HALF)) >> 14);
         x4_ff[l]  <= x3_ff[l];
         s_ff[l]   <= neg_ff[l][3] ? -signed'(mag[l]) : signed'(mag[l]);
      end
      tag_ff[0] <= in_tag;
      for (int s = 1; s < STAGES; s++) begin
         tag_ff[s] <= tag_ff[s-1];
      end
   end

   // valid pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_tag   = tag_ff[STAGES-1];
   assign out_sin   = s_ff[0];
   assign out_cos   = s_ff[1];
   assign busy      = |valid_ff;

endmodule

### src/tmvg_builder.sv
// builds the ring and tube angle tables after reset and each register write
// depends on tmvg_pkg and tmvg_sincos
module tmvg_builder
   import tmvg_pkg::*;
#(
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] ring_div,
   input  logic [DIV_W-1:0] tube_div,
   input  logic [RAD_W-1:0] major_radius,
   input  logic [RAD_W-1:0] minor_radius,
   output table_wr_type     table_wr,
   output logic             done
);

   localparam int SHIFT = 28 - FRACTION_BITS;
   localparam int DIV_STEPS = ANGLE_W + 1;

   typedef enum logic [3:0] {
      B_DIV   = 4'b0001,
      B_SWEEP = 4'b0010,
      B_DRAIN = 4'b0100,
      B_DONE  = 4'b1000
   } build_state_type;

   build_state_type state_ff;
   logic [4:0]         step_ff;
   logic [TAG_W-1:0]   k_ff;
   logic [DIV_W-1:0]   rem_ff   [2];
   logic [DIV_STEPS-1:0] quo_ff [2];
   logic [ANGLE_W-1:0] angle_ff [2];
   logic [DIV_W-1:0]   frac_ff  [2];

   logic [DIV_W-1:0] divisor [2];
   logic [DIV_W:0]   trial   [2];
   logic             ge      [2];
   logic [DIV_W:0]   fsum    [2];
   logic             carry   [2];

   logic                     rv, tv_unused_valid;
   logic [TAG_W-1:0]         rtag;
   logic signed [TRIG_W-1:0] rsin, rcos, tsin, tcos;
   logic                     rbusy, tbusy;

   logic                    p1_valid_ff, p2_valid_ff;
   logic [TAG_W-1:0]        p1_tag_ff, p2_tag_ff;
   logic signed [RHO_W-1:0] rc_ff, rs_ff;
   tube_entry_type          tube1_ff, tube_cur_ff, tube_prev_ff;
   ring_entry_type          ring_cur_ff, ring_prev_ff;
   logic signed [WIDE_W-1:0] zw;

   assign divisor[0] = ring_div;
   assign divisor[1] = tube_div;

   // restoring divide of one full turn, and the angle step
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         trial[l] = {(step_ff == '0) ? '0 : rem_ff[l], step_ff == '0};
         ge[l]    = trial[l] >= {1'b0, divisor[l]};
         fsum[l]  = {1'b0, frac_ff[l]} + {1'b0, rem_ff[l]};
         carry[l] = fsum[l] >= {1'b0, divisor[l]};
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset || start) begin
         state_ff <= B_DIV;
         step_ff  <= '0;
         k_ff     <= '0;
      end else begin
         unique case (state_ff)
            B_DIV: begin
               step_ff <= step_ff + 5'd1;
               k_ff    <= '0;
               if (step_ff == 5'(DIV_STEPS - 1)) begin
                  state_ff <= B_SWEEP;
               end
            end
            B_SWEEP: begin
               k_ff <= k_ff + TAG_W'(1);
               if (k_ff == TAG_W'(ROWS)) begin
                  state_ff <= B_DRAIN;
               end
            end
            B_DRAIN: begin
               if (!rbusy && !tbusy && !p1_valid_ff && !p2_valid_ff) begin
                  state_ff <= B_DONE;
               end
            end
            B_DONE: begin
               state_ff <= B_DONE;
            end
            default: state_ff <= B_DIV;
         endcase
      end
   end

   // divider and angle accumulators
   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         if (state_ff == B_DIV) begin
            rem_ff[l]   <= ge[l] ? DIV_W'(trial[l] - {1'b0, divisor[l]}) : DIV_W'(trial[l]);
            quo_ff[l]   <= {quo_ff[l][DIV_STEPS-2:0], ge[l]};
            angle_ff[l] <= '0;
            frac_ff[l]  <= '0;
         end else if (state_ff == B_SWEEP) begin
            frac_ff[l]  <= carry[l] ? DIV_W'(fsum[l] - {1'b0, divisor[l]}) : DIV_W'(fsum[l]);
            angle_ff[l] <= angle_ff[l] + ANGLE_W'(quo_ff[l]) + ANGLE_W'(carry[l]);
         end
      end
   end

   tmvg_sincos u_ring_trig (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (state_ff == B_SWEEP),
      .in_angle  (angle_ff[0]),
      .in_tag    (k_ff),
      .out_valid (rv),
      .out_tag   (rtag),
      .out_sin   (rsin),
      .out_cos   (rcos),
      .busy      (rbusy)
   );

   tmvg_sincos u_tube_trig (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (state_ff == B_SWEEP),
      .in_angle  (angle_ff[1]),
      .in_tag    (k_ff),
      .out_valid (tv_unused_valid),
      .out_tag   (),
      .out_sin   (tsin),
      .out_cos   (tcos),
      .busy      (tbusy)
   );

   // z from the scaled ring sine, rounded half up
   always_comb begin
      zw = (WIDE_W'(rs_ff) <<< 14) + (WIDE_W'(1) <<< (SHIFT - 1));
   end

   // radius products, then rho and z
   always_ff @(posedge clock) begin
      rc_ff     <= RHO_W'(signed'({1'b0, minor_radius})) * RHO_W'(rcos);
      rs_ff     <= RHO_W'(signed'({1'b0, minor_radius})) * RHO_W'(rsin);
      tube1_ff  <= '{cosv: tcos, sinv: tsin};
      p1_tag_ff <= rtag;
      ring_cur_ff.rho <= RHO_W'(signed'({1'b0, major_radius, 14'b0})) + rc_ff;
      ring_cur_ff.z   <= sat_pos(zw >>> SHIFT);
      tube_cur_ff     <= tube1_ff;
      p2_tag_ff       <= p1_tag_ff;
      if (p2_valid_ff) begin
         ring_prev_ff <= ring_cur_ff;
         tube_prev_ff <= tube_cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= rv && tv_unused_valid;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   // row k-1 gets entries k-1 and k
   always_comb begin
      table_wr.en        = p2_valid_ff && (p2_tag_ff != '0);
      table_wr.addr      = IDX_W'(p2_tag_ff - TAG_W'(1));
      table_wr.ring.lo   = ring_prev_ff;
      table_wr.ring.hi   = ring_cur_ff;
      table_wr.tube.lo   = tube_prev_ff;
      table_wr.tube.hi   = tube_cur_ff;
   end

   assign done = (state_ff == B_DONE);

endmodule

### src/tmvg_front.sv
// input side: takes cell items, flags bad indexes, queues them
// depends on tmvg_pkg
module tmvg_front
   import tmvg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,
   input  logic [DIV_W-1:0] ring_div,
   input  logic [DIV_W-1:0] tube_div,
   input  logic             table_ready,
   input  logic             pop,
   output queue_out_type    head
);

   cell_type            q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;
   cell_type            cell_in;
   logic                push;

   // classify the incoming item
   always_comb begin
      cell_in.ring_idx = req_tdata[IDX_W-1:0];
      cell_in.tube_idx = req_tdata[2*IDX_W-1:IDX_W];
      cell_in.bad      = ({1'b0, cell_in.ring_idx} >= ring_div) ||
                         ({1'b0, cell_in.tube_idx} >= tube_div);
   end

   assign req_tready = table_ready && (count_ff != (QPTR_W+1)'(QDEPTH));
   assign push       = req_tvalid && req_tready;

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cell_in;
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];

endmodule

### src/tmvg_back.sv
// result side: steps six vertex slots per valid cell (one per bad cell) through the tables and multipliers
// depends on tmvg_pkg
module tmvg_back
   import tmvg_pkg::*;
#(
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
)(
   input  logic          clock,
   input  logic          reset,
   input  table_wr_type  table_wr,
   input  queue_out_type head,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,
   output logic          rsp_tlast,
   output logic          rsp_tuser
);

   localparam int SHIFT = 28 - FRACTION_BITS;

   ring_row_type ring_mem [ROWS];
   tube_row_type tube_mem [ROWS];

   logic              adv, emit, last;
   logic [SLOT_W-1:0] slot_ff;

   ring_row_type      ring_rd_ff;
   tube_row_type      tube_rd_ff;
   logic              s1_valid_ff, s1_last_ff, s1_bad_ff;
   logic [SLOT_W-1:0] s1_slot_ff;

   logic                     s2_valid_ff, s2_last_ff, s2_bad_ff;
   logic [SLOT_W-1:0]        s2_slot_ff;
   logic signed [PROD_W-1:0] px_ff, py_ff;
   logic signed [POS_W-1:0]  z2_ff;

   logic                     rsp_valid_ff, rsp_last_ff, rsp_bad_ff;
   logic [SLOT_W-1:0]        rsp_slot_ff;
   logic signed [POS_W-1:0]  pos_x_ff, pos_y_ff, pos_z_ff;

   ring_entry_type           ring_sel;
   tube_entry_type           tube_sel;
   logic signed [WIDE_W-1:0] xw, yw;

   // table writes from the builder
   always_ff @(posedge clock) begin
      if (table_wr.en) begin
         ring_mem[table_wr.addr] <= table_wr.ring;
         tube_mem[table_wr.addr] <= table_wr.tube;
      end
   end

   assign adv  = !rsp_valid_ff || rsp_tready;
   assign emit = adv && head.valid;
   assign last = head.item.bad || (slot_ff == LAST_SLOT);
   assign pop  = emit && last;

   // slot counter over the head cell
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (emit) begin
         slot_ff <= last ? '0 : slot_ff + SLOT_W'(1);
      end
   end

   // table read
   always_ff @(posedge clock) begin
      if (adv) begin
         ring_rd_ff <= ring_mem[head.item.ring_idx];
         tube_rd_ff <= tube_mem[head.item.tube_idx];
         s1_slot_ff <= slot_ff;
         s1_last_ff <= last;
         s1_bad_ff  <= head.item.bad;
      end
   end

   // angle pair for the slot
   always_comb begin
      ring_sel = next_ring(s1_slot_ff) ? ring_rd_ff.hi : ring_rd_ff.lo;
      tube_sel = next_tube(s1_slot_ff) ? tube_rd_ff.hi : tube_rd_ff.lo;
   end

   // rho times cos and sin of phi
   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff      <= PROD_W'(ring_sel.rho) * PROD_W'(tube_sel.cosv);
         py_ff      <= PROD_W'(ring_sel.rho) * PROD_W'(tube_sel.sinv);
         z2_ff      <= ring_sel.z;
         s2_slot_ff <= s1_slot_ff;
         s2_last_ff <= s1_last_ff;
         s2_bad_ff  <= s1_bad_ff;
      end
   end

   // round half up to the output fraction
   always_comb begin
      xw = WIDE_W'(px_ff) + (WIDE_W'(1) <<< (SHIFT - 1));
      yw = WIDE_W'(py_ff) + (WIDE_W'(1) <<< (SHIFT - 1));
   end

   // output register
   always_ff @(posedge clock) begin
      if (adv) begin
         pos_x_ff    <= s2_bad_ff ? '0 : sat_pos(xw >>> SHIFT);
         pos_y_ff    <= s2_bad_ff ? '0 : sat_pos(yw >>> SHIFT);
         pos_z_ff    <= s2_bad_ff ? '0 : z2_ff;
         rsp_slot_ff <= s2_bad_ff ? '0 : s2_slot_ff;
         rsp_last_ff <= s2_last_ff;
         rsp_bad_ff  <= s2_bad_ff;
      end
   end

   // valid pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= emit;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_slot_ff, pos_z_ff, pos_y_ff, pos_x_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

endmodule

### tb/tb_torus_mesh_vertex_generator.sv
// testbench for the torus mesh vertex generator: drives grid cells and register
// writes, predicts every vertex in fixed point and checks each result field
// depends on tmvg_pkg and the torus_mesh_vertex_generator top level
`timescale 1ns / 1ps
module tb_torus_mesh_vertex_generator;
   import tmvg_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 40;
   // slots that take the next ring / tube angle, bit k for slot k
   localparam logic [5:0] RING_STEP = 6'b010110;
   localparam logic [5:0] TUBE_STEP = 6'b011010;

   typedef struct {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic [SLOT_W-1:0]       slot;
      logic                    last;
      logic                    bad;
   } vertex_type;

   typedef struct {
      logic [7:0] ring;
      logic [7:0] tube;
      logic       typed_bad;   // expected result typed in: one flagged zero vertex
   } cell_row_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [15:0]      req_tdata;   // ring_index, tube_index
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [63:0]      rsp_tdata;   // pos_x, pos_y, pos_z, vertex_slot
   logic             rsp_tlast;
   logic             rsp_tuser;   // bad_index
   logic             csr_wen;
   logic [1:0]       csr_index;
   logic [DIV_W-1:0] csr_wdata;

   vertex_type  vertex_queue[$];
   int          error_count;
   int          cycle_count;
   int          ring_div;
   int          tube_div;
   int          major_r;
   int          minor_r;

   torus_mesh_vertex_generator u_dut (.*);

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // q1.14 sine from a 16-bit turn fraction
   function automatic int sine_q14(input logic [15:0] angle);
      int unsigned q, f, x, x2, t, v, s;
      q = 32'(angle[15:14]);
      f = 32'(angle[13:0]);
      x = q[0] ? ONE_Q14 - f : f;
      x2 = (x * x + Q14_HALF) >> 14;
      t = (POLY_C * x2 + Q14_HALF) >> 14;
      v = ((POLY_B - t) * x2 + Q14_HALF) >> 14;
      s = (x * (POLY_A - v) + Q14_HALF) >> 14;
      if (s > ONE_Q14) s = ONE_Q14;
      return q[1] ? -int'(s) : int'(s);
   endfunction

   // q.28 to output format, round half up, saturate
   function automatic logic signed [POS_W-1:0] to_coord(input longint v);
      longint r;
      r = (v + (longint'(1) << 19)) >>> 20;
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
      return POS_W'(r);
   endfunction

   function automatic logic [15:0] turn_of(input int k, input int n);
      longint q;
      q = (longint'(k) << 16) / n;
      return q[15:0];
   endfunction

   // expected vertices of one cell
   function automatic void predict_cell(input logic [7:0] ring, input logic [7:0] tube);
      vertex_type vtx;
      logic [15:0] t, p;
      longint rho;
      if (ring_div == 0 || tube_div == 0 || ring >= ring_div || tube >= tube_div) begin
         vtx = '{x: 0, y: 0, z: 0, slot: 0, last: 1'b1, bad: 1'b1};
         vertex_queue.push_back(vtx);
         return;
      end
      for (int k = 0; k < 6; k++) begin
         t = turn_of(int'(ring) + int'(RING_STEP[k]), ring_div);
         p = turn_of(int'(tube) + int'(TUBE_STEP[k]), tube_div);
         rho = longint'(major_r) * ONE_Q14 + longint'(minor_r) * sine_q14(t + 16'd16384);
         vtx.x = to_coord(rho * sine_q14(p + 16'd16384));
         vtx.y = to_coord(rho * sine_q14(p));
         vtx.z = to_coord(longint'(minor_r) * sine_q14(t) * ONE_Q14);
         vtx.slot = SLOT_W'(k);
         vtx.last = (k == 5);
         vtx.bad = 1'b0;
         vertex_queue.push_back(vtx);
      end
   endfunction

   // register write, mirrored in the predictor; the caller drops csr_wen
   task automatic write_reg(input csr_index_type idx, input int value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= DIV_W'(value);
      @(posedge clock);
      case (idx)
         CSR_RING_DIV: ring_div = ((value & 511) > 256) ? 256 : (value & 511);
         CSR_TUBE_DIV: tube_div = ((value & 511) > 256) ? 256 : (value & 511);
         CSR_MAJOR:    major_r = value & 8'hFF;
         CSR_MINOR:    minor_r = value & 8'hFF;
         default: ;
      endcase
   endtask

   // wait for all results, then let the pipeline settle
   task automatic drain();
      while (vertex_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_shape(input int rd, input int td, input int maj, input int mnr);
      drain();
      write_reg(CSR_RING_DIV, rd);
      write_reg(CSR_TUBE_DIV, td);
      write_reg(CSR_MAJOR, maj);
      write_reg(CSR_MINOR, mnr);
      csr_wen <= 1'b0;
   endtask

   // send one cell, hold valid until accepted, then an optional gap
   task automatic send_cell(input logic [7:0] ring, input logic [7:0] tube,
                            input logic typed_bad, input int gap);
      vertex_type vtx;
      req_tvalid <= 1'b1;
      req_tdata <= {tube, ring};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (typed_bad) begin
         vtx = '{x: 0, y: 0, z: 0, slot: 0, last: 1'b1, bad: 1'b1};
         vertex_queue.push_back(vtx);
      end else begin
         predict_cell(ring, tube);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // random cells, mostly inside the grid, in bursts
   task automatic random_cells(input int count);
      int burst, gap;
      logic [7:0] ring, tube;
      burst = 0;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0 || ring_div == 0 || tube_div == 0) begin
            ring = 8'($urandom);
            tube = 8'($urandom);
         end else begin
            ring = 8'($urandom_range(0, ring_div - 1));
            tube = 8'($urandom_range(0, tube_div - 1));
         end
         if (burst == 0) begin
            burst = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end
         burst--;
         send_cell(ring, tube, 1'b0, (burst == 0) ? gap : 0);
      end
      req_tvalid <= 1'b0;
   endtask

   // directed cells at reset shape (20 x 20)
   cell_row_type directed_rows[] = '{
      '{8'd0,   8'd0,   1'b0},
      '{8'd19,  8'd19,  1'b0},
      '{8'd0,   8'd19,  1'b0},
      '{8'd19,  8'd0,   1'b0},
      '{8'd5,   8'd10,  1'b0},
      '{8'd20,  8'd0,   1'b1},
      '{8'd0,   8'd20,  1'b1},
      '{8'd255, 8'd255, 1'b1},
      '{8'd128, 8'd3,   1'b1},
      '{8'd3,   8'd128, 1'b1},
      '{8'd10,  8'd15,  1'b0}
   };

   // stimulus
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wen = 1'b0;
      csr_index = CSR_RING_DIV;
      csr_wdata = '0;
      error_count = 0;
      ring_div = RST_DIVISIONS;
      tube_div = RST_DIVISIONS;
      major_r = RST_MAJOR;
      minor_r = RST_MINOR;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n])
         send_cell(directed_rows[n].ring, directed_rows[n].tube,
                   directed_rows[n].typed_bad, n % 3);
      random_cells(50);

      set_shape(1, 1, 0, 0);
      send_cell(8'd0, 8'd0, 1'b0, 0);
      send_cell(8'd1, 8'd0, 1'b1, 0);
      random_cells(30);

      // largest grid and radii
      set_shape(256, 256, 255, 255);
      send_cell(8'd255, 8'd255, 1'b0, 0);
      random_cells(70);

      // oversized counts clamp to the maximum
      set_shape(300, 511, 200, 55);
      random_cells(50);

      // zero divisions: every cell is out of range
      set_shape(0, 0, 1, 1);
      send_cell(8'd0, 8'd0, 1'b1, 0);
      random_cells(20);

      set_shape(7, 13, 37, 9);
      random_cells(70);

      set_shape($urandom_range(1, 256), $urandom_range(1, 256),
                $urandom_range(0, 255), $urandom_range(0, 255));
      random_cells(60);

      set_shape(256, 3, 0, 255);
      random_cells(60);

      drain();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // result side: check each accepted vertex, stall on a shifting pattern
   always @(posedge clock) begin
      vertex_type exp_v;
      logic signed [POS_W-1:0] got_x, got_y, got_z;
      logic [SLOT_W-1:0] got_slot;
      int mode;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_x = rsp_tdata[17:0];
            got_y = rsp_tdata[35:18];
            got_z = rsp_tdata[53:36];
            got_slot = rsp_tdata[56:54];
            if (vertex_queue.size() == 0) begin
               $error("vertex with nothing expected");
               error_count++;
            end else begin
               exp_v = vertex_queue.pop_front();
               if (got_x !== exp_v.x) begin
                  $error("pos_x expected %0d got %0d", exp_v.x, got_x);
                  error_count++;
               end
               if (got_y !== exp_v.y) begin
                  $error("pos_y expected %0d got %0d", exp_v.y, got_y);
                  error_count++;
               end
               if (got_z !== exp_v.z) begin
                  $error("pos_z expected %0d got %0d", exp_v.z, got_z);
                  error_count++;
               end
               if (got_slot !== exp_v.slot) begin
                  $error("vertex_slot expected %0d got %0d", exp_v.slot, got_slot);
                  error_count++;
               end
               if (rsp_tlast !== exp_v.last) begin
                  $error("last_vertex expected %0d got %0d", exp_v.last, rsp_tlast);
                  error_count++;
               end
               if (rsp_tuser !== exp_v.bad) begin
                  $error("bad_index expected %0d got %0d", exp_v.bad, rsp_tuser);
                  error_count++;
               end
            end
         end
         // pattern: always ready, half, then mostly stalled, in turn as cycle_count advances
         mode = (cycle_count >> 7) % 3;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial cycle_count = 0;

endmodule

### filelist.f
+incdir+src
src/tmvg_pkg.sv
src/tmvg_sincos.sv
src/tmvg_builder.sv
src/tmvg_front.sv
src/tmvg_back.sv
src/torus_mesh_vertex_generator.sv
tb/tb_torus_mesh_vertex_generator.sv
